// ===== rtl/vat_pkg.sv =====
// Shared constants and types for the 4x4 matrix-vector transform unit.
// No dependencies; the RTL files refer to it by scoped names, the testbench imports it.
`default_nettype none

package vat_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int FRAC_BITS  = 16;
  localparam int FIELD_W    = 32;
  localparam int CFG_W      = 64;
  localparam int NUM_REGS   = 8;
  localparam int REG_IDX_W  = $clog2(NUM_REGS);
  localparam int CFG_IDX_W  = 4;
  localparam int NUM_LANES  = 4;
  localparam int NUM_COLS   = 4;
  localparam int PROD_W     = 2 * DATA_WIDTH;
  localparam int PAIR_W     = PROD_W + 1;
  localparam int SUM_W      = PROD_W + 2;

  typedef logic signed [DATA_WIDTH-1:0] data_t;
  typedef data_t vec_t [NUM_COLS];
  typedef logic [CFG_W-1:0] cfg_word_t;

  localparam cfg_word_t CFG_RESET [NUM_REGS] = '{
    64'd65536, 64'd0, 64'd281474976710656, 64'd0,
    64'd0, 64'd65536, 64'd0, 64'd281474976710656
  };

  localparam data_t SAT_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam data_t SAT_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic out;
  } stage_en_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] value;
    logic                         clip;
  } lane_res_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] out_x;
    logic signed [FIELD_W-1:0] out_y;
    logic signed [FIELD_W-1:0] out_z;
    logic signed [FIELD_W-1:0] out_w;
    logic                      saturated;
  } res_t;

endpackage

`default_nettype wire

// ===== rtl/vat_vec_if.sv =====
// Input channel: one 4-component Q16.16 vector per item.
// Depends on vat_pkg.
`default_nettype none

interface vat_vec_if;
  logic                               valid;
  logic                               ready;
  logic signed [vat_pkg::FIELD_W-1:0] in_x;
  logic signed [vat_pkg::FIELD_W-1:0] in_y;
  logic signed [vat_pkg::FIELD_W-1:0] in_z;
  logic signed [vat_pkg::FIELD_W-1:0] in_w;

  modport source (output valid, output in_x, output in_y, output in_z, output in_w,
                  input ready);
  modport sink (input valid, input in_x, input in_y, input in_z, input in_w,
                output ready);
endinterface

`default_nettype wire

// ===== rtl/vat_res_if.sv =====
// Output channel: one transformed vector and a saturation flag per item.
// Depends on vat_pkg.
`default_nettype none

interface vat_res_if;
  logic                               valid;
  logic                               ready;
  logic signed [vat_pkg::FIELD_W-1:0] out_x;
  logic signed [vat_pkg::FIELD_W-1:0] out_y;
  logic signed [vat_pkg::FIELD_W-1:0] out_z;
  logic signed [vat_pkg::FIELD_W-1:0] out_w;
  logic                               saturated;

  modport source (output valid, output out_x, output out_y, output out_z, output out_w,
                  output saturated, input ready);
  modport sink (input valid, input out_x, input out_y, input out_z, input out_w,
                input saturated, output ready);
endinterface

`default_nettype wire

// ===== rtl/vat_lane.sv =====
// One row lane: four multipliers, a two-level registered adder tree,
// then arithmetic shift and saturation. Depends on vat_pkg.
`default_nettype none

module vat_lane (
  input  wire logic                clk,
  input  wire vat_pkg::stage_en_t  en,
  input  wire vat_pkg::vec_t       vec,
  input  wire vat_pkg::vec_t       coef,
  output vat_pkg::lane_res_t       res
);

  logic signed [vat_pkg::PROD_W-1:0] prod [vat_pkg::NUM_COLS];
  logic signed [vat_pkg::PAIR_W-1:0] pair [2];
  logic signed [vat_pkg::SUM_W-1:0]  total;
  logic signed [vat_pkg::SUM_W-1:0]  shifted;
  logic [vat_pkg::SUM_W-vat_pkg::DATA_WIDTH:0] upper;
  logic                              fits;

  always_ff @(posedge clk) begin
    if (en.s1) begin
      for (int c = 0; c < vat_pkg::NUM_COLS; c++) begin
        prod[c] <= coef[c] * vec[c];
      end
    end
    if (en.s2) begin
      pair[0] <= vat_pkg::PAIR_W'(prod[0]) + vat_pkg::PAIR_W'(prod[1]);
      pair[1] <= vat_pkg::PAIR_W'(prod[2]) + vat_pkg::PAIR_W'(prod[3]);
    end
    if (en.s3) begin
      total <= vat_pkg::SUM_W'(pair[0]) + vat_pkg::SUM_W'(pair[1]);
    end
  end

  always_comb begin
    shifted = total >>> vat_pkg::FRAC_BITS;
    upper   = shifted[vat_pkg::SUM_W-1:vat_pkg::DATA_WIDTH-1];
    fits    = (&upper) | (~|upper);
    res.clip = ~fits;
    if (fits) begin
      res.value = shifted[vat_pkg::DATA_WIDTH-1:0];
    end else if (shifted[vat_pkg::SUM_W-1]) begin
      res.value = vat_pkg::SAT_MIN;
    end else begin
      res.value = vat_pkg::SAT_MAX;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/vat_merge.sv =====
// Output register: gathers the four lane results and merges their clip flags.
// Depends on vat_pkg.
`default_nettype none

module vat_merge (
  input  wire logic                clk,
  input  wire vat_pkg::stage_en_t  en,
  input  wire vat_pkg::lane_res_t  lane [vat_pkg::NUM_LANES],
  output vat_pkg::res_t            res
);

  logic any_clip;

  always_comb begin
    any_clip = 1'b0;
    for (int l = 0; l < vat_pkg::NUM_LANES; l++) begin
      any_clip = any_clip | lane[l].clip;
    end
  end

  always_ff @(posedge clk) begin
    if (en.out) begin
      res.out_x     <= vat_pkg::FIELD_W'(lane[0].value);
      res.out_y     <= vat_pkg::FIELD_W'(lane[1].value);
      res.out_z     <= vat_pkg::FIELD_W'(lane[2].value);
      res.out_w     <= vat_pkg::FIELD_W'(lane[3].value);
      res.saturated <= any_clip;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/vec4_affine_transform_unit.sv =====
// Top level of the 4x4 matrix-vector transform: configuration registers,
// pipeline valid tracking, four row lanes and the output merge.
// Depends on vat_pkg, vat_vec_if, vat_res_if, vat_lane, vat_merge.
//
//   channel | direction | handshake   | payload
//   vec     | in        | valid/ready | in_x, in_y, in_z, in_w
//   res     | out       | valid/ready | out_x, out_y, out_z, out_w, saturated
//   cfg     | in        | cfg_wr_en   | cfg_index, cfg_wr_data
//
// One item per cycle while res is not stalled; the accepting edge registers the products,
// then the pair add, the final add and shift/saturate into the output register
// follow as registered steps in that order.
// Each stage advances when its successor is empty or advancing, so a stall on
// res backs up stage by stage and vec.ready falls only when all stages hold.
// rst clears the valid bits and loads the identity matrix.
`default_nettype none

module vec4_affine_transform_unit (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_wr_en,
  input  wire logic [vat_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [vat_pkg::CFG_W-1:0]         cfg_wr_data,
  vat_vec_if.sink                                vec,
  vat_res_if.source                              res
);

  vat_pkg::cfg_word_t  cfg_regs [vat_pkg::NUM_REGS];
  logic                v1;
  logic                v2;
  logic                v3;
  logic                vo;
  vat_pkg::stage_en_t  en;
  vat_pkg::vec_t       vin;
  vat_pkg::vec_t       row_coef [vat_pkg::NUM_LANES];
  vat_pkg::lane_res_t  lane_res [vat_pkg::NUM_LANES];
  vat_pkg::res_t       res_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < vat_pkg::NUM_REGS; i++) begin
        cfg_regs[i] <= vat_pkg::CFG_RESET[i];
      end
    end else if (cfg_wr_en && (cfg_index < vat_pkg::CFG_IDX_W'(vat_pkg::NUM_REGS))) begin
      cfg_regs[cfg_index[vat_pkg::REG_IDX_W-1:0]] <= cfg_wr_data;
    end
  end

  always_comb begin
    en.out = ~vo | res.ready;
    en.s3  = ~v3 | en.out;
    en.s2  = ~v2 | en.s3;
    en.s1  = ~v1 | en.s2;
  end

  assign vec.ready = en.s1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      vo <= 1'b0;
    end else begin
      if (en.s1) begin
        v1 <= vec.valid;
      end
      if (en.s2) begin
        v2 <= v1;
      end
      if (en.s3) begin
        v3 <= v2;
      end
      if (en.out) begin
        vo <= v3;
      end
    end
  end

  assign vin[0] = vec.in_x[vat_pkg::DATA_WIDTH-1:0];
  assign vin[1] = vec.in_y[vat_pkg::DATA_WIDTH-1:0];
  assign vin[2] = vec.in_z[vat_pkg::DATA_WIDTH-1:0];
  assign vin[3] = vec.in_w[vat_pkg::DATA_WIDTH-1:0];

  for (genvar r = 0; r < vat_pkg::NUM_LANES; r++) begin : g_lane
    for (genvar c = 0; c < vat_pkg::NUM_COLS; c++) begin : g_col
      assign row_coef[r][c] =
        cfg_regs[2*r + c/2][(c%2)*vat_pkg::FIELD_W +: vat_pkg::DATA_WIDTH];
    end

    vat_lane u_lane (
      .clk  (clk),
      .en   (en),
      .vec  (vin),
      .coef (row_coef[r]),
      .res  (lane_res[r])
    );
  end

  vat_merge u_merge (
    .clk  (clk),
    .en   (en),
    .lane (lane_res),
    .res  (res_q)
  );

  assign res.valid     = vo;
  assign res.out_x     = res_q.out_x;
  assign res.out_y     = res_q.out_y;
  assign res.out_z     = res_q.out_z;
  assign res.out_w     = res_q.out_w;
  assign res.saturated = res_q.saturated;

  a_sat_value : assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.saturated) |->
      (res_q.out_x == vat_pkg::FIELD_W'(vat_pkg::SAT_MAX) ||
       res_q.out_x == vat_pkg::FIELD_W'(vat_pkg::SAT_MIN) ||
       res_q.out_y == vat_pkg::FIELD_W'(vat_pkg::SAT_MAX) ||
       res_q.out_y == vat_pkg::FIELD_W'(vat_pkg::SAT_MIN) ||
       res_q.out_z == vat_pkg::FIELD_W'(vat_pkg::SAT_MAX) ||
       res_q.out_z == vat_pkg::FIELD_W'(vat_pkg::SAT_MIN) ||
       res_q.out_w == vat_pkg::FIELD_W'(vat_pkg::SAT_MAX) ||
       res_q.out_w == vat_pkg::FIELD_W'(vat_pkg::SAT_MIN)))
    else $error("saturated flag without a clipped component");

  a_no_idle_stall : assert property (@(posedge clk) disable iff (rst)
    !res.valid |-> vec.ready)
    else $error("input stalled with empty output register");

  a_advance : assert property (@(posedge clk) disable iff (rst)
    (v3 && en.out) |=> res.valid)
    else $error("item lost between last stage and output register");

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
// Self-checking testbench for the 4x4 fixed-point matrix-vector transform unit.
// Drives vectors and matrix settings, predicts or looks up each result and checks it field by field.
// Depends on vat_pkg, vat_vec_if, vat_res_if and vec4_affine_transform_unit.

module testbench;
  import vat_pkg::*;

  localparam logic [31:0] MAXV      = 32'h7FFF_FFFF;
  localparam logic [31:0] MINV      = 32'h8000_0000;
  localparam logic [31:0] ONE_Q     = 32'h0001_0000;
  localparam logic [31:0] NEG_ONE_Q = 32'hFFFF_0000;
  localparam logic [31:0] HALF_Q    = 32'h0000_8000;
  localparam logic [31:0] NEG_LSB   = 32'hFFFF_FFFF;
  localparam int ACC_W        = 2 * DATA_WIDTH + 2;
  localparam int DRAIN_CYCLES = 8;
  localparam int STUCK_LIMIT  = 400;
  localparam int PHASE_ITEMS  = 125;
  localparam int REPORT_MAX   = 10;

  typedef enum {SET_RESET, SET_BAD_INDEX, SET_ALL_MAX, SET_ALL_MIN, SET_EDGE} matrix_setting_e;
  typedef enum {MIX_FULL, MIX_SMALL, MIX_BLEND} coef_mix_e;

  typedef struct {
    logic signed [FIELD_W-1:0] x;
    logic signed [FIELD_W-1:0] y;
    logic signed [FIELD_W-1:0] z;
    logic signed [FIELD_W-1:0] w;
    bit                        fixed;
    res_t                      want;
  } vec_item_t;

  typedef struct {
    matrix_setting_e setting;
    vec_item_t       item;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic                 cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  cfg_word_t            cfg_wr_data;

  vat_vec_if vec_ch ();
  vat_res_if res_ch ();

  vec4_affine_transform_unit dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wr_data (cfg_wr_data),
    .vec         (vec_ch),
    .res         (res_ch)
  );

  always #5 clk = ~clk;

  cfg_word_t matrix [NUM_REGS];
  vec_item_t vec_backlog [$];
  res_t      pending_results [$];
  vec_item_t head;
  res_t      got;
  res_t      want;
  bit        idle_on = 1'b1;
  int        in_gap;
  int        out_gap;
  int        stuck;
  int        fail_count;
  int        items_in;
  int        results_checked;
  int        settings_loaded;

  dir_row_t plan [18] = '{
    '{SET_RESET, '{32'h0, 32'h0, 32'h0, 32'h0, 1'b1, {32'h0, 32'h0, 32'h0, 32'h0, 1'b0}}},
    '{SET_RESET, '{MAXV, MAXV, MAXV, MAXV, 1'b1, {MAXV, MAXV, MAXV, MAXV, 1'b0}}},
    '{SET_RESET, '{MINV, MINV, MINV, MINV, 1'b1, {MINV, MINV, MINV, MINV, 1'b0}}},
    '{SET_RESET, '{MAXV, MINV, 32'h1, NEG_LSB, 1'b1, {MAXV, MINV, 32'h1, NEG_LSB, 1'b0}}},
    '{SET_RESET, '{32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_0F0F, 32'hF0F0_F0F0, 1'b1,
                   {32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_0F0F, 32'hF0F0_F0F0, 1'b0}}},
    '{SET_BAD_INDEX, '{ONE_Q, NEG_ONE_Q, 32'h1234_5678, 32'h9ABC_DEF0, 1'b1,
                       {ONE_Q, NEG_ONE_Q, 32'h1234_5678, 32'h9ABC_DEF0, 1'b0}}},
    '{SET_ALL_MAX, '{MAXV, MAXV, MAXV, MAXV, 1'b1, {MAXV, MAXV, MAXV, MAXV, 1'b1}}},
    '{SET_ALL_MAX, '{MINV, MINV, MINV, MINV, 1'b1, {MINV, MINV, MINV, MINV, 1'b1}}},
    '{SET_ALL_MAX, '{32'h0, 32'h0, 32'h0, 32'h0, 1'b1, {32'h0, 32'h0, 32'h0, 32'h0, 1'b0}}},
    '{SET_ALL_MIN, '{MINV, MINV, MINV, MINV, 1'b1, {MAXV, MAXV, MAXV, MAXV, 1'b1}}},
    '{SET_ALL_MIN, '{MAXV, MAXV, MAXV, MAXV, 1'b1, {MINV, MINV, MINV, MINV, 1'b1}}},
    '{SET_ALL_MIN, '{32'h1, 32'h0, 32'h0, 32'h0, 1'b1,
                     {32'hFFFF_8000, 32'hFFFF_8000, 32'hFFFF_8000, 32'hFFFF_8000, 1'b0}}},
    '{SET_EDGE, '{MAXV, 32'h1, 32'h0, 32'h0, 1'b0, '0}},
    '{SET_EDGE, '{MINV, NEG_LSB, 32'h0, 32'h0, 1'b0, '0}},
    '{SET_EDGE, '{NEG_LSB, 32'h0, 32'h0, 32'h0, 1'b0, '0}},
    '{SET_EDGE, '{MAXV, 32'h0, 32'h0, 32'h0, 1'b0, '0}},
    '{SET_EDGE, '{MINV, 32'h0, 32'h0, MINV, 1'b0, '0}},
    '{SET_EDGE, '{MAXV, 32'h0, 32'h0, MAXV, 1'b0, '0}}
  };

  coef_mix_e mix_plan [6] = '{MIX_BLEND, MIX_SMALL, MIX_FULL, MIX_BLEND, MIX_SMALL, MIX_SMALL};

  function automatic res_t transform_vec(input vec_item_t v);
    logic signed [ACC_W-1:0] acc;
    logic signed [ACC_W-1:0] coef_ext;
    logic signed [ACC_W-1:0] comp_ext;
    logic signed [ACC_W-1:0] lim_hi;
    logic signed [ACC_W-1:0] lim_lo;
    data_t     vin [NUM_COLS];
    data_t     lane [NUM_LANES];
    data_t     cf;
    cfg_word_t word;
    logic [31:0] half;
    logic      clip;
    res_t      r;
    lim_hi = SAT_MAX;
    lim_lo = SAT_MIN;
    vin[0] = v.x[DATA_WIDTH-1:0];
    vin[1] = v.y[DATA_WIDTH-1:0];
    vin[2] = v.z[DATA_WIDTH-1:0];
    vin[3] = v.w[DATA_WIDTH-1:0];
    clip = 1'b0;
    for (int row = 0; row < NUM_LANES; row++) begin
      acc = '0;
      for (int col = 0; col < NUM_COLS; col++) begin
        word = matrix[2 * row + col / 2];
        half = (col % 2 == 1) ? word[63:32] : word[31:0];
        cf = half[DATA_WIDTH-1:0];
        coef_ext = cf;
        comp_ext = vin[col];
        acc = acc + coef_ext * comp_ext;
      end
      acc = acc >>> FRAC_BITS;
      if (acc > lim_hi) begin
        lane[row] = SAT_MAX;
        clip = 1'b1;
      end else if (acc < lim_lo) begin
        lane[row] = SAT_MIN;
        clip = 1'b1;
      end else begin
        lane[row] = acc[DATA_WIDTH-1:0];
      end
    end
    r.out_x = lane[0];
    r.out_y = lane[1];
    r.out_z = lane[2];
    r.out_w = lane[3];
    r.saturated = clip;
    return r;
  endfunction

  function automatic logic [31:0] extreme_val();
    case ($urandom_range(0, 4))
      0: return MAXV;
      1: return MINV;
      2: return 32'h0;
      3: return ONE_Q;
      default: return NEG_LSB;
    endcase
  endfunction

  function automatic logic [31:0] rand_field();
    case ($urandom_range(0, 9))
      0: return extreme_val();
      1, 2, 3, 4: return $urandom;
      default: return $urandom_range(0, 32'h01FF_FFFF) - 32'h0100_0000;
    endcase
  endfunction

  function automatic logic [31:0] rand_coef(input coef_mix_e mix);
    logic [31:0] small_coef;
    small_coef = $urandom_range(0, 32'h0007_FFFF) - 32'h0004_0000;
    if (mix == MIX_SMALL)
      return small_coef;
    case ($urandom_range(0, 9))
      0: return extreme_val();
      1, 2: return $urandom;
      3: return ONE_Q;
      4: return 32'h0;
      default: return small_coef;
    endcase
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input cfg_word_t word);
    cfg_wr_en   <= 1'b1;
    cfg_index   <= idx;
    cfg_wr_data <= word;
    @(posedge clk);
    if (idx < NUM_REGS)
      matrix[idx[REG_IDX_W-1:0]] = word;
  endtask

  task automatic load_matrix(input cfg_word_t m [NUM_REGS]);
    for (int i = 0; i < NUM_REGS; i++)
      write_reg(i[CFG_IDX_W-1:0], m[i]);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    settings_loaded++;
  endtask

  task automatic drain();
    while (vec_backlog.size() != 0 || pending_results.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic apply_setting(input matrix_setting_e setting);
    cfg_word_t m [NUM_REGS];
    m = matrix;
    case (setting)
      SET_BAD_INDEX: begin
        for (int i = NUM_REGS; i < 2 ** CFG_IDX_W; i++)
          write_reg(i[CFG_IDX_W-1:0], '1);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
      end
      SET_ALL_MAX: begin
        foreach (m[i]) m[i] = {MAXV, MAXV};
        load_matrix(m);
      end
      SET_ALL_MIN: begin
        foreach (m[i]) m[i] = {MINV, MINV};
        load_matrix(m);
      end
      SET_EDGE: begin
        m = '{{ONE_Q, ONE_Q}, 64'h0, {32'h0, HALF_Q}, 64'h0,
              {32'h0, NEG_ONE_Q}, 64'h0, {32'h0, ONE_Q}, {ONE_Q, 32'h0}};
        load_matrix(m);
      end
      default: ;
    endcase
  endtask

  task automatic load_random_matrix(input coef_mix_e mix);
    cfg_word_t m [NUM_REGS];
    write_reg(CFG_IDX_W'($urandom_range(NUM_REGS, 2 ** CFG_IDX_W - 1)), {$urandom, $urandom});
    foreach (m[i]) begin
      if (mix == MIX_FULL)
        m[i] = {$urandom, $urandom};
      else
        m[i] = {rand_coef(mix), rand_coef(mix)};
    end
    load_matrix(m);
  endtask

  // vector source: hold valid until accepted, insert idle bursts between items
  always @(posedge clk) begin
    if (rst) begin
      vec_ch.valid <= 1'b0;
      in_gap = 0;
    end else begin
      if (vec_ch.valid && vec_ch.ready) begin
        head = vec_backlog.pop_front();
        pending_results.push_back(head.fixed ? head.want : transform_vec(head));
        items_in++;
      end
      if (vec_ch.valid && !vec_ch.ready) begin
      end else if (in_gap > 0) begin
        in_gap--;
        vec_ch.valid <= 1'b0;
      end else if (idle_on && vec_backlog.size() != 0 && $urandom_range(0, 5) == 0) begin
        in_gap = $urandom_range(0, 3);
        vec_ch.valid <= 1'b0;
      end else if (vec_backlog.size() != 0) begin
        vec_ch.valid <= 1'b1;
        vec_ch.in_x  <= vec_backlog[0].x;
        vec_ch.in_y  <= vec_backlog[0].y;
        vec_ch.in_z  <= vec_backlog[0].z;
        vec_ch.in_w  <= vec_backlog[0].w;
      end else begin
        vec_ch.valid <= 1'b0;
      end
    end
  end

  // result sink: check against the oldest prediction, stall in bursts
  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
      out_gap = 0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        got.out_x     = res_ch.out_x;
        got.out_y     = res_ch.out_y;
        got.out_z     = res_ch.out_z;
        got.out_w     = res_ch.out_w;
        got.saturated = res_ch.saturated;
        if (pending_results.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_MAX)
            $display("unexpected result %h %h %h %h sat %b",
                     got.out_x, got.out_y, got.out_z, got.out_w, got.saturated);
        end else begin
          want = pending_results.pop_front();
          results_checked++;
          if (got.out_x !== want.out_x || got.out_y !== want.out_y ||
              got.out_z !== want.out_z || got.out_w !== want.out_w ||
              got.saturated !== want.saturated) begin
            fail_count++;
            if (fail_count <= REPORT_MAX)
              $display("result %0d: expected %h %h %h %h sat %b, got %h %h %h %h sat %b",
                       results_checked, want.out_x, want.out_y, want.out_z, want.out_w,
                       want.saturated, got.out_x, got.out_y, got.out_z, got.out_w,
                       got.saturated);
          end
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        res_ch.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_gap = $urandom_range(0, 3);
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (vec_ch.valid && vec_ch.ready) || (res_ch.valid && res_ch.ready) ||
        (vec_backlog.size() == 0 && pending_results.size() == 0)) begin
      stuck <= 0;
    end else if (stuck >= STUCK_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
               stuck, pending_results.size());
      $display("status: fail");
      $finish;
    end else begin
      stuck <= stuck + 1;
    end
  end

  initial begin
    matrix_setting_e last_setting;
    vec_item_t item;
    matrix = '{{32'h0, ONE_Q}, 64'h0, {ONE_Q, 32'h0}, 64'h0,
               64'h0, {32'h0, ONE_Q}, 64'h0, {ONE_Q, 32'h0}};
    cfg_wr_en    = 1'b0;
    cfg_index    = '0;
    cfg_wr_data  = '0;
    vec_ch.valid = 1'b0;
    vec_ch.in_x  = '0;
    vec_ch.in_y  = '0;
    vec_ch.in_z  = '0;
    vec_ch.in_w  = '0;
    res_ch.ready = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    settings_loaded = 1;

    last_setting = SET_RESET;
    for (int i = 0; i < $size(plan); i++) begin
      if (plan[i].setting != last_setting) begin
        drain();
        apply_setting(plan[i].setting);
        last_setting = plan[i].setting;
      end
      vec_backlog.push_back(plan[i].item);
    end

    for (int ph = 0; ph < $size(mix_plan); ph++) begin
      drain();
      if (ph == $size(mix_plan) - 1)
        idle_on = 1'b0;
      load_random_matrix(mix_plan[ph]);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        item.x = rand_field();
        item.y = rand_field();
        item.z = rand_field();
        item.w = rand_field();
        item.fixed = 1'b0;
        item.want = '0;
        vec_backlog.push_back(item);
      end
    end

    drain();
    $display("transformed %0d vectors under %0d matrix settings, incl. saturating extremes",
             items_in, settings_loaded);
    $display("checked %0d results, %0d mismatches", results_checked, fail_count);
    if (fail_count == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
